@@ rtl/tgjc_pkg.sv @@
// ----------------------------------------------------------------------------
// Tripod gait joint commands: shared package
// Widths, fixed-point constants and the pipeline control type shared by the
// top level and the sine unit.
// ----------------------------------------------------------------------------
package tgjc_pkg;

   // Phase and angle widths.
   localparam int PHASE_BITS_DEFAULT = 10;
   localparam int ANGLE_BITS = 16;

   // Leg numbering.
   localparam logic [2:0] FIRST_LEG = 3'd0;
   localparam logic [2:0] LAST_LEG = 3'd5;
   localparam logic [2:0] FIRST_RIGHT_LEG = 3'd3;

   // Angle offsets in a 16-bit turn.
   localparam logic [15:0] HALF_TURN = 16'h8000;
   localparam logic [15:0] QUARTER_TURN = 16'h4000;
   localparam logic [15:0] NO_TURN = 16'h0000;

   // Quarter-wave sine polynomial, Q16.
   localparam logic [16:0] Q16_ONE = 17'd65536;
   localparam logic [12:0] POLY_C3 = 13'd4640;
   localparam logic [15:0] POLY_C2 = 16'd42047;
   localparam logic [16:0] POLY_C1 = 17'd102944;
   localparam logic [14:0] SINE_MAX = 15'd4096;

   // Gait constants, Q12 or Q13.
   localparam logic signed [12:0] STRIDE_GAIN = 13'sd3277;   // 0.8
   localparam logic signed [17:0] TURN_UNITY = 18'sd8192;    // 1.0 in Q13
   localparam logic signed [15:0] KNEE_BASE = 16'sd1638;     // 0.4
   localparam logic signed [11:0] KNEE_GAIN = 12'sd819;      // 0.2
   localparam logic signed [15:0] KNEE_LOW = -16'sd819;      // -0.2
   localparam logic signed [12:0] ANKLE_GAIN = -13'sd2867;   // -0.7
   localparam logic signed [15:0] QUIET_LIMIT = 16'sd41;     // 0.01

   localparam logic signed [15:0] Q12_MAX = 16'sh7FFF;
   localparam logic signed [15:0] Q12_MIN = -16'sh8000;

   typedef logic signed [15:0] q12_type;
   typedef logic signed [13:0] trig_type;

   // Control word that travels with each leg through the pipeline.
   typedef struct packed {
      logic       valid;
      logic [2:0] leg;
      logic       zero;
   } ctl_type;

endpackage

@@ rtl/tgjc_sine.sv @@
// ----------------------------------------------------------------------------
// Tripod gait joint commands: pipelined sine unit
// Four register stages evaluate the quarter-wave polynomial of a 16-bit
// angle and return a Q12 sine with the quadrant sign applied.
// ----------------------------------------------------------------------------
module tgjc_sine (
   input  logic              clock,
   input  logic              en,
   input  logic [15:0]       angle,
   output tgjc_pkg::trig_type value
);
   import tgjc_pkg::*;

   logic [1:0]  quad;
   logic [16:0] z_fold;
   logic [16:0] z_raw;
   logic [33:0] z_sq;

   logic [16:0] z1_ff, z2_ff, z3_ff;
   logic        neg1_ff, neg2_ff, neg3_ff;
   logic [16:0] zz1_ff, zz2_ff;
   logic [15:0] inner2_ff;
   logic [16:0] mid3_ff;
   trig_type    value_ff;

   logic [29:0] t1_prod;
   logic [15:0] inner_in;
   logic [32:0] t2_prod;
   logic [16:0] mid_in;
   logic [33:0] s_prod;
   logic [17:0] s_val;
   logic [14:0] q_val;
   logic [14:0] q_cap;
   trig_type    value_in;

   // Fold the angle onto the first quadrant and square it.
   always_comb begin
      quad = angle[15:14];
      z_raw = {1'b0, angle[13:0], 2'b00};
      z_fold = quad[0] ? (Q16_ONE - z_raw) : z_raw;
      z_sq = {17'd0, z_fold} * {17'd0, z_fold};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         z1_ff <= z_fold;
         neg1_ff <= quad[1];
         zz1_ff <= z_sq[32:16];
      end
   end

   // Innermost polynomial term.
   always_comb begin
      t1_prod = {13'd0, zz1_ff} * {17'd0, POLY_C3};
      inner_in = POLY_C2 - {2'b00, t1_prod[29:16]};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         z2_ff <= z1_ff;
         neg2_ff <= neg1_ff;
         zz2_ff <= zz1_ff;
         inner2_ff <= inner_in;
      end
   end

   // Middle polynomial term.
   always_comb begin
      t2_prod = {16'd0, zz2_ff} * {17'd0, inner2_ff};
      mid_in = POLY_C1 - t2_prod[32:16];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         z3_ff <= z2_ff;
         neg3_ff <= neg2_ff;
         mid3_ff <= mid_in;
      end
   end

   // Final product, rounding to Q12, cap at one and quadrant sign.
   always_comb begin
      s_prod = {17'd0, z3_ff} * {17'd0, mid3_ff};
      s_val = s_prod[33:16];
      q_val = {1'b0, s_val[17:4]} + {14'd0, s_val[3]};
      q_cap = (q_val > SINE_MAX) ? SINE_MAX : q_val;
      value_in = neg3_ff ? -trig_type'(q_cap[13:0]) : trig_type'(q_cap[13:0]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         value_ff <= value_in;
      end
   end

   assign value = value_ff;

endmodule

@@ rtl/tripod_gait_joint_commands_top.sv @@
// ----------------------------------------------------------------------------
// Tripod gait joint commands: top level
// Turns one gait phase and motion command word into six leg words of hip,
// knee and ankle commands through a seven-stage pipeline.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                                   Direction   Word
//  req       req_valid/req_ready + 5 fields          in          phase, speeds, turn
//  rsp       rsp_valid/rsp_ready + 5 fields          out         one leg's commands
//  csr       csr_valid/csr_ready + csr_noise_mode    in          noise mode bit
//
//  A sequencer issues one leg per cycle into the pipeline while it advances,
//  six legs per input word, and the next word is taken in the cycle of the last leg.
//  Reset clears the sequencer, the stage valid bits and the noise mode bit.
//  When rsp_ready is low with a word waiting, every stage holds in place.
//  The csr port is always ready.
// ----------------------------------------------------------------------------
module tripod_gait_joint_commands_top #(
   parameter int PHASE_BITS = tgjc_pkg::PHASE_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [PHASE_BITS-1:0]  req_gait_phase,
   input  tgjc_pkg::q12_type      req_forward_speed,
   input  tgjc_pkg::q12_type      req_lateral_speed,
   input  tgjc_pkg::q12_type      req_vertical_speed,
   input  tgjc_pkg::q12_type      req_turn_rate,

   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [2:0]             rsp_leg_index,
   output tgjc_pkg::q12_type      rsp_hip_command,
   output tgjc_pkg::q12_type      rsp_knee_command,
   output tgjc_pkg::q12_type      rsp_ankle_command,
   output logic                   rsp_last_leg,

   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic                   csr_noise_mode
);
   import tgjc_pkg::*;

   // Pipeline advance: the output register is empty or being drained.
   logic adv;
   logic req_fire;

   // Configuration register.
   logic noise_ff;

   // Sequencer and captured input word.
   logic        busy_ff;
   logic [2:0]  leg_ff;
   logic [15:0] itm_angle_ff;
   q12_type     itm_fwd_ff;
   q12_type     itm_turn_ff;
   logic        itm_zero_ff;

   logic        idle_in;
   logic        quiet_in;
   logic [15:0] leg_angle;
   logic [15:0] cos_angle;

   // Stage registers.
   ctl_type s1_ctl_ff, s2_ctl_ff, s3_ctl_ff, s4_ctl_ff, s5_ctl_ff, s6_ctl_ff;
   logic signed [28:0] s1_pfwd_ff;
   q12_type            s1_turn_ff;
   q12_type            s2_stride_ff;
   logic signed [17:0] s2_tf_ff;
   logic signed [16:0] s2_tside_ff, s3_tside_ff, s4_tside_ff;
   logic signed [33:0] s3_pst_ff, s4_pst_ff;
   logic signed [47:0] s5_h1_ff;
   logic signed [30:0] s5_h2_ff;
   logic signed [25:0] s5_pk_ff;
   logic               s5_spos_ff;
   q12_type            s6_hip_ff;
   q12_type            s6_knee_ff;

   trig_type sin_val;
   trig_type cos_val;

   logic               rsp_valid_ff;
   logic [2:0]         rsp_leg_ff;
   q12_type            rsp_hip_ff;
   q12_type            rsp_knee_ff;
   q12_type            rsp_ankle_ff;
   logic               rsp_last_ff;

   // Stage 2 combinational terms.
   logic signed [28:0] stride_sum;
   logic               s1_left;
   logic signed [16:0] turn_wide;
   logic signed [16:0] turn_mag;
   logic               turn_inner;
   logic signed [17:0] tf_in;
   logic signed [16:0] tside_in;

   // Stage 6 and output combinational terms.
   logic signed [47:0] h_sum;
   logic signed [47:0] h_rnd;
   logic signed [22:0] hip_wide;
   q12_type            hip_in;
   logic signed [25:0] pk_rnd;
   q12_type            knee_in;
   logic signed [28:0] pa_prod;
   logic signed [28:0] pa_rnd;
   q12_type            ankle_in;

   assign adv = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv && (!busy_ff || (leg_ff == LAST_LEG));
   assign req_fire = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // Noise mode register.
   always_ff @(posedge clock) begin
      if (reset) begin
         noise_ff <= 1'b0;
      end else if (csr_valid) begin
         noise_ff <= csr_noise_mode;
      end
   end

   // Zero-command conditions, decided once per input word.
   always_comb begin
      idle_in = (req_forward_speed == 16'sd0) && (req_lateral_speed == 16'sd0) &&
                (req_vertical_speed == 16'sd0) && (req_turn_rate == 16'sd0);
      quiet_in = noise_ff &&
                 (req_forward_speed < QUIET_LIMIT) && (req_forward_speed > -QUIET_LIMIT) &&
                 (req_lateral_speed < QUIET_LIMIT) && (req_lateral_speed > -QUIET_LIMIT) &&
                 (req_turn_rate < QUIET_LIMIT) && (req_turn_rate > -QUIET_LIMIT);
   end

   // Leg sequencer: one leg is issued per advancing cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         leg_ff <= FIRST_LEG;
      end else if (adv) begin
         if (req_fire) begin
            busy_ff <= 1'b1;
            leg_ff <= FIRST_LEG;
         end else if (busy_ff) begin
            if (leg_ff == LAST_LEG) begin
               busy_ff <= 1'b0;
            end else begin
               leg_ff <= leg_ff + 3'd1;
            end
         end
      end
   end

   // Captured input word.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         itm_angle_ff <= {req_gait_phase, {(ANGLE_BITS - PHASE_BITS){1'b0}}};
         itm_fwd_ff <= req_forward_speed;
         itm_turn_ff <= req_turn_rate;
         itm_zero_ff <= idle_in || quiet_in;
      end
   end

   // Odd legs run half a turn later; cosine is a quarter turn ahead.
   assign leg_angle = itm_angle_ff + (leg_ff[0] ? HALF_TURN : NO_TURN);
   assign cos_angle = leg_angle + QUARTER_TURN;

   tgjc_sine u_sine (
      .clock (clock),
      .en    (adv),
      .angle (leg_angle),
      .value (sin_val)
   );

   tgjc_sine u_cosine (
      .clock (clock),
      .en    (adv),
      .angle (cos_angle),
      .value (cos_val)
   );

   // Control words travel alongside the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff <= '0;
         s2_ctl_ff <= '0;
         s3_ctl_ff <= '0;
         s4_ctl_ff <= '0;
         s5_ctl_ff <= '0;
         s6_ctl_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_ctl_ff <= '{valid: busy_ff, leg: leg_ff, zero: itm_zero_ff};
         s2_ctl_ff <= s1_ctl_ff;
         s3_ctl_ff <= s2_ctl_ff;
         s4_ctl_ff <= s3_ctl_ff;
         s5_ctl_ff <= s4_ctl_ff;
         s6_ctl_ff <= s5_ctl_ff;
         rsp_valid_ff <= s6_ctl_ff.valid;
      end
   end

   // Stage 1: forward speed times the stride gain.
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_pfwd_ff <= 29'(itm_fwd_ff) * 29'(STRIDE_GAIN);
         s1_turn_ff <= itm_turn_ff;
      end
   end

   // Stage 2: rounded stride, turn factor and signed turn term.
   always_comb begin
      stride_sum = s1_pfwd_ff + 29'sd2048;
      s1_left = s1_ctl_ff.leg < FIRST_RIGHT_LEG;
      turn_wide = 17'(s1_turn_ff);
      turn_mag = (s1_turn_ff < 16'sd0) ? -turn_wide : turn_wide;
      turn_inner = ((s1_turn_ff > 16'sd0) && s1_left) ||
                   ((s1_turn_ff < 16'sd0) && !s1_left);
      tf_in = turn_inner ? (TURN_UNITY - 18'(turn_mag)) : (TURN_UNITY + 18'(turn_mag));
      tside_in = s1_left ? -turn_wide : turn_wide;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_stride_ff <= stride_sum[27:12];
         s2_tf_ff <= tf_in;
         s2_tside_ff <= tside_in;
      end
   end

   // Stage 3: stride times turn factor.
   always_ff @(posedge clock) begin
      if (adv) begin
         s3_pst_ff <= 34'(s2_stride_ff) * 34'(s2_tf_ff);
         s3_tside_ff <= s2_tside_ff;
      end
   end

   // Stage 4: wait for the sine unit.
   always_ff @(posedge clock) begin
      if (adv) begin
         s4_pst_ff <= s3_pst_ff;
         s4_tside_ff <= s3_tside_ff;
      end
   end

   // Stage 5: products with sine and cosine.
   always_ff @(posedge clock) begin
      if (adv) begin
         s5_h1_ff <= 48'(s4_pst_ff) * 48'(sin_val);
         s5_h2_ff <= 31'(s4_tside_ff) * 31'(cos_val);
         s5_pk_ff <= 26'(sin_val) * 26'(KNEE_GAIN);
         s5_spos_ff <= sin_val > 14'sd0;
      end
   end

   // Stage 6: hip sum with rounding and saturation; knee lift.
   always_comb begin
      h_sum = s5_h1_ff + (48'(s5_h2_ff) <<< 12);
      h_rnd = h_sum + 48'sd16777216;
      hip_wide = h_rnd[47:25];
      if (hip_wide > 23'(Q12_MAX)) begin
         hip_in = Q12_MAX;
      end else if (hip_wide < 23'(Q12_MIN)) begin
         hip_in = Q12_MIN;
      end else begin
         hip_in = hip_wide[15:0];
      end
      pk_rnd = s5_pk_ff + 26'sd2048;
      knee_in = s5_spos_ff ? (KNEE_BASE + 16'(pk_rnd[25:12])) : KNEE_LOW;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s6_hip_ff <= hip_in;
         s6_knee_ff <= knee_in;
      end
   end

   // Output stage: ankle from knee, and forced zero commands when idle or quiet.
   always_comb begin
      pa_prod = 29'(s6_knee_ff) * 29'(ANKLE_GAIN);
      pa_rnd = pa_prod + 29'sd2048;
      ankle_in = pa_rnd[27:12];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_leg_ff <= s6_ctl_ff.leg;
         rsp_last_ff <= s6_ctl_ff.leg == LAST_LEG;
         rsp_hip_ff <= s6_ctl_ff.zero ? 16'sd0 : s6_hip_ff;
         rsp_knee_ff <= s6_ctl_ff.zero ? 16'sd0 : s6_knee_ff;
         rsp_ankle_ff <= s6_ctl_ff.zero ? 16'sd0 : ankle_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_leg_index = rsp_leg_ff;
   assign rsp_hip_command = rsp_hip_ff;
   assign rsp_knee_command = rsp_knee_ff;
   assign rsp_ankle_command = rsp_ankle_ff;
   assign rsp_last_leg = rsp_last_ff;

   // The leg counter never runs past the last leg.
   assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (leg_ff <= LAST_LEG))
      else $error("leg counter out of range");

   // Mid-word, an advancing cycle moves to the next leg of the same word.
   assert property (@(posedge clock) disable iff (reset)
      (adv && busy_ff && (leg_ff != LAST_LEG)) |=>
         (busy_ff && (leg_ff == $past(leg_ff) + 3'd1)))
      else $error("sequencer skipped or repeated a leg");

   // A word flagged idle or quiet leaves with all commands zero.
   assert property (@(posedge clock) disable iff (reset)
      (adv && s6_ctl_ff.valid && s6_ctl_ff.zero) |=>
         ((rsp_hip_command == 16'sd0) && (rsp_knee_command == 16'sd0) &&
          (rsp_ankle_command == 16'sd0)))
      else $error("zero-command word carried nonzero commands");

endmodule
